// File: sv/b64e_pkg.sv
// Base64 stream encoder shared package: character and command types,
// alphabet lookup, padding code and queue sizing.
// No dependencies.
`default_nettype none

package b64e_pkg;

  localparam int CMD_DEPTH = 2;

  typedef logic [6:0] char_t;

  localparam char_t PAD_CHAR = 7'h3D;

  typedef enum logic [1:0] {
    PH_0      = 2'd0,
    PH_1      = 2'd1,
    PH_2      = 2'd2,
    PH_UNUSED = 2'd3
  } phase_t;

  typedef struct packed {
    char_t [3:0] chars;
    logic [1:0]  cnt_m1;
    logic        eom;
  } cmd_t;

  function automatic char_t b64_char(input logic [5:0] v);
    char_t c;
    if (v < 6'd26) begin
      c = 7'(v) + 7'h41;
    end else if (v < 6'd52) begin
      c = 7'(v) - 7'd26 + 7'h61;
    end else if (v < 6'd62) begin
      c = 7'(v) - 7'd52 + 7'h30;
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/b64e_front.sv
// Front end: accepts bytes, tracks group phase and carried bits, and builds
// one character command per byte. Depends on b64e_pkg.
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_message,
  output cmd_t            cmd
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      carry_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  always_comb begin
    cmd.chars  = '{default: PAD_CHAR};
    cmd.cnt_m1 = 2'd0;
    cmd.eom    = end_of_message;
    phase_nxt  = PH_0;
    carry_nxt  = '0;
    unique case (phase_r)
      PH_2: begin
        cmd.chars[0] = b64_char({carry_r, data_byte[7:6]});
        cmd.chars[1] = b64_char(data_byte[5:0]);
        cmd.cnt_m1   = 2'd1;
      end
      PH_1: begin
        cmd.chars[0] = b64_char({carry_r[1:0], data_byte[7:4]});
        if (end_of_message) begin
          cmd.chars[1] = b64_char({data_byte[3:0], 2'b00});
          cmd.cnt_m1   = 2'd2;
        end else begin
          phase_nxt = PH_2;
          carry_nxt = data_byte[3:0];
        end
      end
      default: begin
        cmd.chars[0] = b64_char(data_byte[7:2]);
        if (end_of_message) begin
          cmd.chars[1] = b64_char({data_byte[1:0], 4'b0000});
          cmd.cnt_m1   = 2'd3;
        end else begin
          phase_nxt = PH_1;
          carry_nxt = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/b64e_cmd_fifo.sv
// Command queue between front and back end.
// Depends on b64e_pkg.
`default_nettype none

module b64e_cmd_fifo
  import b64e_pkg::*;
#(
  parameter int Depth = CMD_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Depth))
    else $error("command queue count over depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("command queue lost a push");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("command queue pointers disagree with count");

endmodule

`default_nettype wire

// File: sv/b64e_back.sv
// Back end: walks the characters of the head command into the output
// register one per cycle while it is popped or empty. Depends on b64e_pkg.
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t head,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  output char_t     out_char,
  output logic      out_last_char,
  output logic      empty,
  input  wire logic pop
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  char_t      char_r;
  logic       last_r;
  logic       advance, load, final_one;

  assign advance   = !valid_r || pop;
  assign load      = advance && !cmd_empty;
  assign final_one = (idx_r == head.cnt_m1);
  assign cmd_pop   = load && final_one;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (advance) begin
      valid_nxt = !cmd_empty;
    end
    if (load) begin
      idx_nxt = final_one ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= head.chars[idx_r];
      last_r <= head.eom && final_one;
    end
  end

  assign out_char      = char_r;
  assign out_last_char = last_r;
  assign empty         = !valid_r;

endmodule

`default_nettype wire

// File: sv/base64_stream_encoder_core.sv
// Base64 stream encoder top level: front end, command queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_cmd_fifo, b64e_back.
`default_nettype none

// Encodes a byte stream into standard Base64 characters, one per result
// transfer, padding the final group with '=' and flagging the final
// character when a byte carries end_of_message. A byte is taken and
// turned into a command of one to four characters; the back end sends
// one character per cycle while pop is held and a command is waiting.
// The first character of a byte passes through the command queue and the
// output register before it shows on the result ports. full rises when
// CmdDepth commands are waiting for the back end.

module base64_stream_encoder_core
  import b64e_pkg::*;
#(
  parameter int CmdDepth = CMD_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_message,
  input  wire logic       push,
  output logic            full,
  output logic [6:0]      out_char,
  output logic            out_last_char,
  output logic            empty,
  input  wire logic       pop
);

  cmd_t front_cmd, head_cmd;
  logic accept, cmd_empty, cmd_pop;

  assign accept = push && !full;

  b64e_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .data_byte      (in_data_byte),
    .end_of_message (in_end_of_message),
    .cmd            (front_cmd)
  );

  b64e_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_cmd (front_cmd),
    .full     (full),
    .pop      (cmd_pop),
    .head     (head_cmd),
    .empty    (cmd_empty)
  );

  b64e_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head_cmd),
    .cmd_empty     (cmd_empty),
    .cmd_pop       (cmd_pop),
    .out_char      (out_char),
    .out_last_char (out_last_char),
    .empty         (empty),
    .pop           (pop)
  );

endmodule

`default_nettype wire

// File: sim/tb_base64_stream_encoder_core.sv
// Testbench for base64_stream_encoder_core: directed and random byte messages
// checked character by character against a Base64 character tracker class.
// Depends on b64e_pkg and base64_stream_encoder_core.
`timescale 1ns / 100ps

module tb_base64_stream_encoder_core;
  import b64e_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_BYTES = 470;

  typedef struct packed {
    char_t code;
    logic  is_last;
  } b64_sym_t;

  class b64_char_tracker;
    b64_sym_t    pending_chars[$];
    phase_t      grp_phase;
    logic [3:0]  carry;
    int          mismatches;

    function new();
      grp_phase  = PH_0;
      carry      = 4'h0;
      mismatches = 0;
    endfunction

    function char_t sextet_code(logic [5:0] v);
      string alphabet;
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      return char_t'(alphabet[v]);
    endfunction

    function void add_char(char_t code, logic is_last);
      pending_chars.push_back('{code: code, is_last: is_last});
    endfunction

    function void encode_byte(logic [7:0] b, logic eom);
      case (grp_phase)
        PH_2: begin
          add_char(sextet_code({carry, b[7:6]}), 1'b0);
          add_char(sextet_code(b[5:0]), eom);
          grp_phase = PH_0;
          carry     = 4'h0;
        end
        PH_1: begin
          add_char(sextet_code({carry[1:0], b[7:4]}), 1'b0);
          if (eom) begin
            add_char(sextet_code({b[3:0], 2'b00}), 1'b0);
            add_char(PAD_CHAR, 1'b1);
            grp_phase = PH_0;
            carry     = 4'h0;
          end else begin
            grp_phase = PH_2;
            carry     = b[3:0];
          end
        end
        default: begin
          add_char(sextet_code(b[7:2]), 1'b0);
          if (eom) begin
            add_char(sextet_code({b[1:0], 4'h0}), 1'b0);
            add_char(PAD_CHAR, 1'b0);
            add_char(PAD_CHAR, 1'b1);
            grp_phase = PH_0;
            carry     = 4'h0;
          end else begin
            grp_phase = PH_1;
            carry     = {2'b00, b[1:0]};
          end
        end
      endcase
    endfunction

    function void match_char(char_t code, logic is_last);
      b64_sym_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual 0x%02h last %0b",
                 $time, code, is_last);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      if (code !== want.code) begin
        $display("%0t: out_char mismatch: expected 0x%02h, actual 0x%02h",
                 $time, want.code, code);
        mismatches++;
      end
      if (is_last !== want.is_last) begin
        $display("%0t: out_last_char mismatch: expected %0b, actual %0b",
                 $time, want.is_last, is_last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [6:0] out_char;
  logic       out_last_char;
  logic       empty;
  logic       pop = 1'b0;

  b64_char_tracker tracker = new();
  int idle_cycles = 0;
  int bytes_sent = 0;
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;

  base64_stream_encoder_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data_byte     (in_data_byte),
    .in_end_of_message(in_end_of_message),
    .push             (push),
    .full             (full),
    .out_char         (out_char),
    .out_last_char    (out_last_char),
    .empty            (empty),
    .pop              (pop)
  );

  always #5 clk = ~clk;

  function automatic int gap_len(int min_len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return min_len;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic eom);
    int gap;
    gap = tx_idle_on ? gap_len(0) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push              <= 1'b1;
    in_data_byte      <= d;
    in_end_of_message <= eom;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (tracker.pending_chars.size() != 0);
  endtask

  // receiver: pop bursts with random stalls
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      pop <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (rx_idle_on) begin
        pop <= 1'b0;
        repeat (gap_len(1)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        tracker.encode_byte(in_data_byte, in_end_of_message);
      end
      if (pop && !empty) begin
        tracker.match_char(out_char, out_last_char);
      end
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int target;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // single-byte messages: flush with two pads
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // two-byte messages: flush with one pad
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // full groups, top two alphabet entries
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // group boundary crossed before the end flag
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
    wait_drained();

    target = bytes_sent + RANDOM_BYTES;
    for (int seg = 0; seg < 3; seg++) begin
      tx_idle_on = (seg != 1);
      rx_idle_on = (seg != 1);
      while (bytes_sent < target - (2 - seg) * (RANDOM_BYTES / 3)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                          : $urandom_range(1, 12);
        send_message(len);
      end
      // hold input until every pending char is out
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/b64e_pkg.sv
sv/b64e_front.sv
sv/b64e_cmd_fifo.sv
sv/b64e_back.sv
sv/base64_stream_encoder_core.sv
sim/tb_base64_stream_encoder_core.sv
